@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top level of the sequence insert block.
// No dependencies. With SYNTH defined the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/seqins_pkg.sv @@
// Package for the sequence insert block: widths, command and status codes,
// and the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package seqins_pkg;

	// Storage size and derived widths.
	localparam int CAPACITY = 512;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed widths of the item fields.
	localparam int CMD_W  = 2;
	localparam int POS_W  = 9;
	localparam int VAL_W  = 32;
	localparam int ECNT_W = 10;
	localparam int STAT_W = 2;

	// Width that holds both a position and a count for compares.
	localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              latch;      // capture position and value, start shift pointer
		logic              clear_cnt;  // empty the sequence
		logic              inc_cnt;    // one element more
		logic              wr_append;  // write the input value at the current end
		logic              shift_rd;   // read the element under the shift pointer
		logic              wr_place;   // write the latched value at the latched position
		logic              rd_pos;     // read the element at the input position
		logic              resp;       // load the result registers
		logic [STAT_W-1:0] resp_status;
		logic              resp_rdata; // result carries the read data
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;    // sequence holds CAPACITY elements
		logic append;  // input position is at or beyond the count
		logic rd_ok;   // input position addresses a stored element
		logic src_at;  // shift pointer has reached the insert position
	} dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/seqins_ctrl.sv @@
// Controller state machine of the sequence insert block.
// Depends on seqins_pkg for the command and status structs and codes.
`timescale 1ns / 1ps
`default_nettype none

module seqins_ctrl import seqins_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [CMD_W-1:0] command,
	input  wire dp_stat_t         stat,
	output dp_cmd_t               cmd,
	output logic                  busy
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SHIFT = 5'b00010,
		S_DRAIN = 5'b00100,
		S_PLACE = 5'b01000,
		S_READ  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.resp_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (command)
						CMD_CLEAR: begin
							cmd.clear_cnt = 1'b1;
							cmd.resp      = 1'b1;
						end
						CMD_INSERT: begin
							if (stat.full) begin
								cmd.resp        = 1'b1;
								cmd.resp_status = ST_FULL;
							end else if (stat.append) begin
								cmd.wr_append = 1'b1;
								cmd.inc_cnt   = 1'b1;
								cmd.resp      = 1'b1;
							end else begin
								cmd.latch = 1'b1;
								state_d   = S_SHIFT;
							end
						end
						CMD_READ: begin
							if (stat.rd_ok) begin
								cmd.rd_pos = 1'b1;
								state_d    = S_READ;
							end else begin
								cmd.resp        = 1'b1;
								cmd.resp_status = ST_RANGE;
							end
						end
						default: begin
							cmd.resp = 1'b1;
						end
					endcase
				end
			end
			S_SHIFT: begin
				cmd.shift_rd = 1'b1;
				if (stat.src_at) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// The last moved element is written back in this cycle.
				state_d = S_PLACE;
			end
			S_PLACE: begin
				cmd.wr_place = 1'b1;
				cmd.inc_cnt  = 1'b1;
				cmd.resp     = 1'b1;
				state_d      = S_IDLE;
			end
			S_READ: begin
				cmd.resp       = 1'b1;
				cmd.resp_rdata = 1'b1;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/seqins_dp.sv @@
// Datapath of the sequence insert block: element memory, count, shift pointer
// and result registers. Depends on seqins_pkg.
`timescale 1ns / 1ps
`default_nettype none

module seqins_dp import seqins_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic [VAL_W-1:0]  value,
	input  wire dp_cmd_t           cmd,
	output dp_stat_t               stat,
	output logic [VAL_W-1:0]       read_value,
	output logic [ECNT_W-1:0]      element_count,
	output logic [STAT_W-1:0]      status,
	output logic                   done
);

	logic [VAL_W-1:0]  mem [CAPACITY];
	logic [VAL_W-1:0]  rdata_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [IDX_W-1:0]  src_q;
	logic [IDX_W-1:0]  at_q;
	logic [VAL_W-1:0]  value_q;
	logic              valid_s1;
	logic [IDX_W-1:0]  dst_s1;
	logic              done_q;
	logic [VAL_W-1:0]  read_value_q;
	logic [ECNT_W-1:0] element_count_q;
	logic [STAT_W-1:0] status_q;
	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  cnt_ext;
	logic [IDX_W-1:0]  raddr;
	logic [IDX_W-1:0]  waddr;
	logic [VAL_W-1:0]  wdata;
	logic              we;

	// Status toward the controller.
	assign pos_ext     = CMP_W'(position);
	assign cnt_ext     = CMP_W'(count_q);
	assign stat.full   = (count_q >= CNT_W'(CAPACITY));
	assign stat.append = (pos_ext >= cnt_ext);
	assign stat.rd_ok  = (pos_ext < cnt_ext) && (pos_ext < CMP_W'(CAPACITY));
	assign stat.src_at = (src_q == at_q);

	// Memory port selection; the moved element, the appended value and the
	// placed value are never written in the same cycle.
	assign raddr = cmd.shift_rd ? src_q : IDX_W'(position);
	always_comb begin
		we    = 1'b0;
		waddr = at_q;
		wdata = value_q;
		if (valid_s1) begin
			we    = 1'b1;
			waddr = dst_s1;
			wdata = rdata_q;
		end else if (cmd.wr_append) begin
			we    = 1'b1;
			waddr = IDX_W'(count_q);
			wdata = value;
		end else if (cmd.wr_place) begin
			we = 1'b1;
		end
	end

	// Element memory with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.shift_rd || cmd.rd_pos) begin
			rdata_q <= mem[raddr];
		end
	end

	// Count after the current command.
	always_comb begin
		count_d = count_q;
		if (cmd.clear_cnt) begin
			count_d = '0;
		end else if (cmd.inc_cnt) begin
			count_d = count_q + CNT_W'(1);
		end
	end

	// Control registers: count, shift pipeline valid, result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			count_q  <= count_d;
			valid_s1 <= cmd.shift_rd;
			done_q   <= cmd.resp;
		end
	end

	// Shift pointer walks down from the last element to the insert position.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			value_q <= value;
			at_q    <= IDX_W'(position);
			src_q   <= IDX_W'(count_q - CNT_W'(1));
		end else if (cmd.shift_rd) begin
			src_q <= src_q - IDX_W'(1);
		end
		if (cmd.shift_rd) begin
			dst_s1 <= src_q + IDX_W'(1);
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			read_value_q    <= cmd.resp_rdata ? rdata_q : '0;
			element_count_q <= ECNT_W'(count_d);
			status_q        <= cmd.resp_status;
		end
	end

	assign read_value    = read_value_q;
	assign element_count = element_count_q;
	assign status        = status_q;
	assign done          = done_q;

endmodule

`default_nettype wire

@@ hw/rtl/sequence_insert_at_position.sv @@
// Top level of the sequence insert block: controller, datapath and checks.
// Depends on seqins_pkg, seqins_ctrl, seqins_dp and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// An item is taken when start is high and busy is low. Every item gives
// exactly one result, shown for one cycle with done high; the receiver
// cannot stall it, so it must take the result in that cycle. Clear, append
// at the end, an insert into a full sequence, a read out of range and an
// unused command keep busy low and give their result in the cycle after the
// item is taken. A read in range raises busy for one cycle and gives its
// result in the first cycle with busy low again. An insert before the end
// moves every later element one place back through the element memory, one
// element per cycle: busy stays high through the shift, drain and place
// states, and the result is shown in the first cycle with busy low again. The
// element memory is not cleared after reset; no clearing pass is needed.
module sequence_insert_at_position import seqins_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CMD_W-1:0]  command,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic [VAL_W-1:0]  value,
	output logic                   busy,
	output logic                   done,
	output logic [VAL_W-1:0]       read_value,
	output logic [ECNT_W-1:0]      element_count,
	output logic [STAT_W-1:0]      status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Controller.
	seqins_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	// Datapath.
	seqins_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.position      (position),
		.value         (value),
		.cmd           (cmd),
		.stat          (stat),
		.read_value    (read_value),
		.element_count (element_count),
		.status        (status),
		.done          (done)
	);

	// Checks on the result timing and the count.
`include "assert_macros.svh"

	`ASSERT_NEXT(a_accept_progress, clk, arst_n, start && !busy, done || busy, "item neither answered nor in work")
	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, done, !busy, "result shown while an item is in work")
	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, done, element_count <= ECNT_W'(CAPACITY), "count beyond capacity")
	`ASSERT_IMPLIES(a_full_count, clk, arst_n, done && (status == ST_FULL), element_count == ECNT_W'(CAPACITY), "full status with room left")

endmodule

`default_nettype wire

@@ tb/tb_sequence_insert_at_position.sv @@
// Self-checking testbench for sequence_insert_at_position: directed items from a table,
// then random phases that keep the sequence short, fill it to capacity and drain it.
// Depends on seqins_pkg and the sequence_insert_at_position RTL.
`timescale 1ns / 1ps

module tb_sequence_insert_at_position;
	import seqins_pkg::*;

	// The one command code that the block must ignore.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Cycles without any handshake before the run is declared hung. The slowest
	// item is an insert at the front of a sequence one short of full.
	localparam int HANG_LIMIT = 4000;

	// Cycles to watch for stray results after the last expected one.
	localparam int DRAIN_CYCLES = 10;

	// One result item of the block.
	typedef struct packed {
		logic [VAL_W-1:0]  read_value;
		logic [ECNT_W-1:0] element_count;
		logic [STAT_W-1:0] status;
	} seq_result_t;

	// One row of the directed table; known marks a result typed in by hand.
	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
		logic             known;
		seq_result_t      result;
	} stim_row_t;

	// Shapes of the random stimulus.
	typedef enum int {MIX_SHORT, FILL_UP, AT_CAPACITY} stim_mode_t;

	localparam int NUM_DIRECTED = 23;

	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		'{CMD_READ,   9'd0,   32'h0000_0000, 1'b1, '{32'h0, 10'd0, ST_RANGE}},
		'{CMD_INSERT, 9'd511, 32'h7FFF_FFFF, 1'b1, '{32'h0, 10'd1, ST_OK}},
		'{CMD_INSERT, 9'd0,   32'h8000_0000, 1'b1, '{32'h0, 10'd2, ST_OK}},
		'{CMD_INSERT, 9'd1,   32'h0000_0000, 1'b0, '{32'h0, 10'd0, ST_OK}},
		'{CMD_INSERT, 9'd256, 32'hFFFF_FFFF, 1'b0, '{32'h0, 10'd0, ST_OK}},
		'{CMD_INSERT, 9'd2,   32'hA5A5_5A5A, 1'b0, '{32'h0, 10'd0, ST_OK}},
		'{CMD_INSERT, 9'd4,   32'h0000_0001, 1'b0, '{32'h0, 10'd0, ST_OK}},
		'{CMD_READ,   9'd0,   32'hFFFF_FFFF, 1'b0, '{32'h0, 10'd0, ST_OK}},
		'{CMD_READ,   9'd1,   32'h0000_0000, 1'b0, '{32'h0, 10'd0, ST_OK}},
		'{CMD_READ,   9'd2,   32'h0000_0000, 1'b0, '{32'h0, 10'd0, ST_OK}},
		'{CMD_READ,   9'd5,   32'h0000_0000, 1'b0, '{32'h0, 10'd0, ST_OK}},
		'{CMD_READ,   9'd6,   32'h0000_0000, 1'b1, '{32'h0, 10'd6, ST_RANGE}},
		'{CMD_READ,   9'd511, 32'h0000_0000, 1'b1, '{32'h0, 10'd6, ST_RANGE}},
		'{CMD_UNUSED, 9'd511, 32'hFFFF_FFFF, 1'b1, '{32'h0, 10'd6, ST_OK}},
		'{CMD_UNUSED, 9'd0,   32'h0000_0000, 1'b1, '{32'h0, 10'd6, ST_OK}},
		'{CMD_READ,   9'd3,   32'h0000_0000, 1'b0, '{32'h0, 10'd0, ST_OK}},
		'{CMD_CLEAR,  9'd511, 32'hFFFF_FFFF, 1'b1, '{32'h0, 10'd0, ST_OK}},
		'{CMD_READ,   9'd0,   32'h0000_0000, 1'b1, '{32'h0, 10'd0, ST_RANGE}},
		'{CMD_INSERT, 9'd0,   32'h1234_5678, 1'b1, '{32'h0, 10'd1, ST_OK}},
		'{CMD_INSERT, 9'd0,   32'h8765_4321, 1'b0, '{32'h0, 10'd0, ST_OK}},
		'{CMD_READ,   9'd0,   32'h0000_0000, 1'b0, '{32'h0, 10'd0, ST_OK}},
		'{CMD_READ,   9'd1,   32'h0000_0000, 1'b0, '{32'h0, 10'd0, ST_OK}},
		'{CMD_CLEAR,  9'd0,   32'h0000_0000, 1'b1, '{32'h0, 10'd0, ST_OK}}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [CMD_W-1:0]  command = CMD_CLEAR;
	logic [POS_W-1:0]  position = '0;
	logic [VAL_W-1:0]  value = '0;
	logic              busy;
	logic              done;
	logic [VAL_W-1:0]  read_value;
	logic [ECNT_W-1:0] element_count;
	logic [STAT_W-1:0] status;

	// Shadow copy of the sequence, kept in step with accepted items.
	logic [VAL_W-1:0] shadow_seq [CAPACITY];
	int               shadow_len = 0;

	seq_result_t awaited_results [$];

	int  error_count = 0;
	int  hang_cycles = 0;
	bit  idling_on = 1'b1;

	// Tallies for the closing summary.
	int n_items = 0;
	int n_results = 0;
	int n_inserts = 0;
	int n_dropped = 0;
	int n_reads = 0;
	int n_out_of_range = 0;
	int n_clears = 0;
	int n_unused = 0;
	int peak_len = 0;

	sequence_insert_at_position dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.command       (command),
		.position      (position),
		.value         (value),
		.busy          (busy),
		.done          (done),
		.read_value    (read_value),
		.element_count (element_count),
		.status        (status)
	);

	// Free-running clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one accepted item to the shadow sequence and return its result.
	task automatic apply_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val, output seq_result_t res);
		int at;
		int j;
		res = '{read_value: '0, element_count: '0, status: ST_OK};
		case (cmd)
			CMD_CLEAR: begin
				shadow_len = 0;
				n_clears++;
			end
			CMD_INSERT: begin
				n_inserts++;
				if (shadow_len >= CAPACITY) begin
					res.status = ST_FULL;
					n_dropped++;
				end else begin
					// Later elements move one place back; a far position appends.
					at = (int'(pos) < shadow_len) ? int'(pos) : shadow_len;
					for (j = shadow_len; j > at; j--)
						shadow_seq[j] = shadow_seq[j-1];
					shadow_seq[at] = val;
					shadow_len++;
					if (shadow_len > peak_len)
						peak_len = shadow_len;
				end
			end
			CMD_READ: begin
				n_reads++;
				if (int'(pos) < shadow_len) begin
					res.read_value = shadow_seq[pos];
				end else begin
					res.status = ST_RANGE;
					n_out_of_range++;
				end
			end
			default: n_unused++;
		endcase
		res.element_count = shadow_len[ECNT_W-1:0];
	endtask

	// Offer one item, wait for the block to take it and record what it should return.
	// A typed result, where given, takes the place of the predicted one.
	task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val, input logic known, input seq_result_t typed);
		seq_result_t predicted;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		start    <= 1'b1;
		command  <= cmd;
		position <= pos;
		value    <= val;
		do @(posedge clk); while (busy);
		apply_item(cmd, pos, val, predicted);
		awaited_results.push_back(known ? typed : predicted);
		n_items++;
	endtask

	// Random data with the extremes of the signed range mixed in.
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Build and offer one random item shaped by the current phase.
	task automatic offer_random(input stim_mode_t mode);
		int               roll;
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		roll = $urandom_range(0, 99);
		pos  = POS_W'($urandom_range(0, 511));
		case (mode)
			MIX_SHORT: begin
				// Short sequences: positions mostly within the sequence or just past its end.
				if (roll < 4)
					cmd = CMD_CLEAR;
				else if (roll < 8)
					cmd = CMD_UNUSED;
				else if (roll < 55)
					cmd = CMD_INSERT;
				else
					cmd = CMD_READ;
				if ((cmd == CMD_INSERT || cmd == CMD_READ) && $urandom_range(0, 9) > 1)
					pos = POS_W'($urandom_range(0,
						(shadow_len + 1 > 511) ? 511 : shadow_len + 1));
			end
			FILL_UP: begin
				// Mostly appends, some inserts into the body, some reads.
				if (roll < 15) begin
					cmd = CMD_READ;
					if (shadow_len > 0 && roll < 12)
						pos = POS_W'($urandom_range(0, shadow_len - 1));
				end else if (roll < 25) begin
					cmd = CMD_INSERT;
					pos = POS_W'($urandom_range(0, shadow_len));
				end else begin
					cmd = CMD_INSERT;
					pos = POS_W'($urandom_range(511, shadow_len));
				end
			end
			default: begin
				// Full sequence: inserts are dropped, every index reads back.
				if (roll < 45)
					cmd = CMD_INSERT;
				else if (roll < 90)
					cmd = CMD_READ;
				else
					cmd = CMD_UNUSED;
			end
		endcase
		offer_item(cmd, pos, pick_value(), 1'b0, '0);
	endtask

	// Result checker: every strobe must match the oldest awaited result.
	always @(posedge clk) begin
		seq_result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with none awaited: read_value %h count %0d status %0d",
					$time, read_value, element_count, status);
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				n_results++;
				if (read_value !== want.read_value) begin
					$display("%0t: read_value mismatch: expected %h actual %h",
						$time, want.read_value, read_value);
					error_count++;
				end
				if (element_count !== want.element_count) begin
					$display("%0t: element_count mismatch: expected %0d actual %0d",
						$time, want.element_count, element_count);
					error_count++;
				end
				if (status !== want.status) begin
					$display("%0t: status mismatch: expected %0d actual %0d",
						$time, want.status, status);
					error_count++;
				end
			end
		end
	end

	// Watchdog: ends the run when no item is taken and no result appears for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			hang_cycles <= 0;
		end else if (hang_cycles + 1 >= HANG_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding",
				$time, HANG_LIMIT, awaited_results.size());
			$display("tb_sequence_insert_at_position failed");
			$finish;
		end else begin
			hang_cycles <= hang_cycles + 1;
		end
	end

	// Stimulus and end of run.
	initial begin
		int k;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (k = 0; k < NUM_DIRECTED; k++)
			offer_item(DIRECTED[k].command, DIRECTED[k].position, DIRECTED[k].value,
				DIRECTED[k].known, DIRECTED[k].result);

		// Short sequences with frequent clears.
		for (k = 0; k < 200; k++)
			offer_random(MIX_SHORT);

		// Fill to capacity, work at capacity, then empty it again.
		offer_item(CMD_CLEAR, POS_W'($urandom_range(0, 511)), $urandom, 1'b0, '0);
		while (shadow_len < CAPACITY)
			offer_random(FILL_UP);
		for (k = 0; k < 40; k++)
			offer_random(AT_CAPACITY);
		offer_item(CMD_CLEAR, POS_W'($urandom_range(0, 511)), $urandom, 1'b0, '0);

		// Back-to-back items with no idling at the end of the run.
		idling_on = 1'b0;
		for (k = 0; k < 80; k++)
			offer_random(MIX_SHORT);
		start <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items, %0d results: %0d inserts (%0d dropped when full),",
			n_items, n_results, n_inserts, n_dropped);
		$display("%0d reads (%0d out of range), %0d clears, %0d unused codes, peak length %0d.",
			n_reads, n_out_of_range, n_clears, n_unused, peak_len);
		if (error_count == 0)
			$display("tb_sequence_insert_at_position passed");
		else
			$display("tb_sequence_insert_at_position failed");
		$finish;
	end

endmodule
